// ===== design/omrb_pkg.sv =====
// ----------------------------------------------------------------------------
// omrb_pkg
// Shared types and sizes for the ordered memory response buffer.
// ----------------------------------------------------------------------------
package omrb_pkg;

  localparam int ISSUE_DEPTH = 16;
  localparam int ORDER_DEPTH = 64;

  localparam int IQ_AW = $clog2(ISSUE_DEPTH);
  localparam int IQ_CW = IQ_AW + 1;
  localparam int OB_AW = $clog2(ORDER_DEPTH);
  localparam int OB_CW = OB_AW + 1;

  localparam int CNT_W  = 7;
  localparam int SLOT_W = 6;
  localparam int KIND_W = 3;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_RESP    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    K_LOAD    = 3'd0,
    K_STORE   = 3'd1,
    K_ATOM_NR = 3'd2,
    K_ATOM_R  = 3'd3,
    K_SYNC    = 3'd4,
    K_EOK     = 3'd5
  } kind_e;

  typedef enum logic {
    REG_LIMIT   = 1'b0,
    REG_COISSUE = 1'b1
  } reg_e;

  typedef struct packed {
    logic              alz;
    logic [KIND_W-1:0] kind;
  } iq_entry_t;

endpackage

// ===== design/ordered_memory_response_buffer.sv =====
// ----------------------------------------------------------------------------
// ordered_memory_response_buffer
// Issue queue plus in-order completion ring for memory requests.
// ----------------------------------------------------------------------------
// The result word is registered at the accepting edge. Throughput: one word
// per cycle unless stalled; the output register drains while the next word is
// taken, set by the single pass from state registers to result.
// Ordered-ring kinds sit in a memory; the head entry is registered in advance.
// Reset: queues empty, counts zero, inflight_limit 32, unit-ready bypass off.
module ordered_memory_response_buffer
  import omrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [KIND_W-1:0] req_kind_i,
  input  logic              all_lanes_zero_i,
  input  logic [SLOT_W-1:0] resp_slot_i,
  input  logic              latency_ready_i,
  input  logic              bus_ready_i,
  input  logic              vrf_ready_i,
  input  logic              unit_ready_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              accepted_o,
  output logic              retire_valid_o,
  output logic [SLOT_W-1:0] retire_slot_o,
  output logic [KIND_W-1:0] retire_kind_o,
  output logic              initiate_valid_o,
  output logic [KIND_W-1:0] initiate_kind_o,
  output logic [SLOT_W-1:0] initiate_slot_o,
  output logic              initiate_tracked_o,
  output logic              token_return_o,
  output logic              resp_error_o,
  output logic [CNT_W-1:0]  loads_in_flight_o,
  output logic [CNT_W-1:0]  stores_in_flight_o
);

  localparam logic [IQ_CW-1:0] IqDepth = IQ_CW'(ISSUE_DEPTH);
  localparam logic [OB_CW-1:0] ObDepth = OB_CW'(ORDER_DEPTH);
  localparam logic [IQ_AW-1:0] IqLast  = IQ_AW'(ISSUE_DEPTH - 1);
  localparam logic [OB_AW-1:0] ObLast  = OB_AW'(ORDER_DEPTH - 1);

  // configuration
  logic [CNT_W-1:0] limit_q;
  logic             coissue_q;
  logic             cfg_wr;

  // state
  iq_entry_t         iq_q [ISSUE_DEPTH];
  logic [IQ_AW-1:0]  iq_head_q, iq_head_d;
  logic [IQ_CW-1:0]  iq_count_q, iq_count_d;
  logic [KIND_W-1:0] kmem [ORDER_DEPTH];
  logic [KIND_W-1:0] head_kind_q;
  logic [ORDER_DEPTH-1:0] done_q;
  logic [OB_AW-1:0]  ob_head_q, ob_head_d;
  logic [OB_CW-1:0]  ob_count_q, ob_count_d;
  logic [CNT_W-1:0]  ld_cnt_q, ld_cnt_d;
  logic [CNT_W-1:0]  st_cnt_q, st_cnt_d;

  // output register
  logic              out_valid_q;
  logic              acc_q, ret_q, ini_q, trk_q, tok_q, err_q;
  logic [SLOT_W-1:0] ret_slot_q, ini_slot_q;
  logic [KIND_W-1:0] ret_kind_q, ini_kind_q;

  // datapath
  logic              in_acc;
  opcode_e           op;
  logic [IQ_CW-1:0]  iq_sum;
  logic [IQ_AW-1:0]  iq_tail;
  logic              enq_ok;
  logic [OB_CW-1:0]  ob_sum;
  logic [OB_AW-1:0]  ob_tail;
  logic [OB_AW-1:0]  rslot;
  logic [OB_CW-1:0]  roff;
  logic              resp_ok;
  logic              hk_vrf, retire;
  logic [CNT_W-1:0]  ld_mid, st_mid;
  logic [OB_CW-1:0]  ob_count_mid;
  iq_entry_t         qe;
  logic              q_loadish, q_store, q_tracked, init_go;
  logic              zero_done;
  logic              kwr;

  // --------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[2]))
      REG_LIMIT:   prdata = 32'(limit_q);
      REG_COISSUE: prdata = 32'(coissue_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= CNT_W'(32);
      coissue_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_LIMIT:   limit_q   <= pwdata[CNT_W-1:0];
        REG_COISSUE: coissue_q <= pwdata[0];
        default:     ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign op         = opcode_e'(opcode_i);

  // --------------------------------------------------------------------------
  // enqueue
  always_comb begin
    iq_sum  = IQ_CW'(iq_head_q) + iq_count_q;
    iq_tail = (iq_sum >= IqDepth) ? IQ_AW'(iq_sum - IqDepth) : IQ_AW'(iq_sum);
    enq_ok  = (op == OP_ENQUEUE) && (req_kind_i <= K_EOK) && (iq_count_q < IqDepth);
  end

  // response
  always_comb begin
    rslot   = OB_AW'(resp_slot_i);
    roff    = (rslot >= ob_head_q) ? OB_CW'(rslot - ob_head_q)
                                   : OB_CW'(rslot) + ObDepth - OB_CW'(ob_head_q);
    resp_ok = (op == OP_RESP) && (32'(resp_slot_i) < 32'(ORDER_DEPTH)) &&
              (roff < ob_count_q) && !done_q[rslot];
  end

  // retire then initiate
  always_comb begin
    hk_vrf = ((head_kind_q != K_LOAD) && (head_kind_q != K_ATOM_R)) || vrf_ready_i;
    retire = (op == OP_STEP) && (ob_count_q != '0) && done_q[ob_head_q] &&
             latency_ready_i && bus_ready_i && hk_vrf && (coissue_q || unit_ready_i);

    ld_mid       = ld_cnt_q;
    st_mid       = st_cnt_q;
    ob_count_mid = ob_count_q;
    if (retire) begin
      ob_count_mid = ob_count_q - 1'b1;
      if ((head_kind_q == K_LOAD) || (head_kind_q == K_ATOM_NR) ||
          (head_kind_q == K_ATOM_R)) begin
        if (ld_cnt_q != '0) ld_mid = ld_cnt_q - 1'b1;
      end else if (head_kind_q == K_STORE) begin
        if (st_cnt_q != '0) st_mid = st_cnt_q - 1'b1;
      end
    end

    qe        = iq_q[iq_head_q];
    q_loadish = (qe.kind == K_LOAD) || (qe.kind == K_ATOM_NR) || (qe.kind == K_ATOM_R);
    q_store   = (qe.kind == K_STORE);
    q_tracked = (qe.kind != K_EOK);
    init_go   = (op == OP_STEP) && (iq_count_q != '0) &&
                !(q_loadish && (ld_mid >= limit_q)) &&
                !(q_store && (st_mid >= limit_q)) &&
                !(q_tracked && (ob_count_mid >= ObDepth));
    zero_done = (qe.kind != K_SYNC) && qe.alz;

    ob_sum  = OB_CW'(ob_head_q) + ob_count_q;
    ob_tail = (ob_sum >= ObDepth) ? OB_AW'(ob_sum - ObDepth) : OB_AW'(ob_sum);

    ld_cnt_d = ld_mid;
    st_cnt_d = st_mid;
    if (init_go && q_loadish) ld_cnt_d = ld_mid + 1'b1;
    if (init_go && q_store)   st_cnt_d = st_mid + 1'b1;

    ob_head_d  = ob_head_q;
    ob_count_d = ob_count_mid;
    if (retire) ob_head_d = (ob_head_q == ObLast) ? '0 : ob_head_q + 1'b1;
    if (init_go && q_tracked) ob_count_d = ob_count_mid + 1'b1;

    iq_head_d  = iq_head_q;
    iq_count_d = iq_count_q;
    if (init_go) begin
      iq_head_d  = (iq_head_q == IqLast) ? '0 : iq_head_q + 1'b1;
      iq_count_d = iq_count_q - 1'b1;
    end
    if (enq_ok) iq_count_d = iq_count_q + 1'b1;

    kwr = in_acc && init_go && q_tracked;
  end

  // --------------------------------------------------------------------------
  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_head_q  <= '0;
      iq_count_q <= '0;
      ob_head_q  <= '0;
      ob_count_q <= '0;
      ld_cnt_q   <= '0;
      st_cnt_q   <= '0;
    end else if (in_acc) begin
      iq_head_q  <= iq_head_d;
      iq_count_q <= iq_count_d;
      ob_head_q  <= ob_head_d;
      ob_count_q <= ob_count_d;
      ld_cnt_q   <= ld_cnt_d;
      st_cnt_q   <= st_cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && enq_ok) begin
      iq_q[iq_tail] <= '{alz: all_lanes_zero_i, kind: req_kind_i};
    end
    if (kwr) begin
      kmem[ob_tail]   <= qe.kind;
      done_q[ob_tail] <= zero_done;
    end
    if (in_acc && resp_ok) begin
      done_q[rslot] <= 1'b1;
    end
  end

  // head kind read ahead into a register, with write forwarding
  logic [OB_AW-1:0] rd_addr;
  assign rd_addr = in_acc ? ob_head_d : ob_head_q;

  always_ff @(posedge clk_i) begin
    if (kwr && (ob_tail == rd_addr)) begin
      head_kind_q <= qe.kind;
    end else begin
      head_kind_q <= kmem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q      <= enq_ok;
      ret_q      <= retire;
      ret_slot_q <= retire ? SLOT_W'(ob_head_q) : '0;
      ret_kind_q <= retire ? head_kind_q : '0;
      ini_q      <= init_go;
      ini_kind_q <= init_go ? qe.kind : '0;
      trk_q      <= init_go && q_tracked;
      ini_slot_q <= (init_go && q_tracked) ? SLOT_W'(ob_tail) : '0;
      tok_q      <= init_go && q_tracked && zero_done;
      err_q      <= (op == OP_RESP) && !resp_ok;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = acc_q;
  assign retire_valid_o     = ret_q;
  assign retire_slot_o      = ret_slot_q;
  assign retire_kind_o      = ret_kind_q;
  assign initiate_valid_o   = ini_q;
  assign initiate_kind_o    = ini_kind_q;
  assign initiate_slot_o    = ini_slot_q;
  assign initiate_tracked_o = trk_q;
  assign token_return_o     = tok_q;
  assign resp_error_o       = err_q;
  assign loads_in_flight_o  = ld_cnt_q;
  assign stores_in_flight_o = st_cnt_q;

  // --------------------------------------------------------------------------
  // checks
  a_ob_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_count_q <= ObDepth)
    else $error("ordered ring count overflow");

  a_iq_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    iq_count_q <= IqDepth)
    else $error("issue queue count overflow");

  a_trk_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (trk_q || tok_q) |-> ini_q)
    else $error("tracked or token without initiate");

  a_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op == OP_RESP) |=> !ret_q && !ini_q && !acc_q)
    else $error("response word retired or initiated");

endmodule
